// ----- rtl/hashed_value_noise_octaves_assert.svh -----
// ----------------------------------------------------------------------------
// hashed_value_noise_octaves_assert.svh
// Assertion macros shared by the noise block; they vanish under synthesis.
// ----------------------------------------------------------------------------
`ifndef HASHED_VALUE_NOISE_OCTAVES_ASSERT_SVH
`define HASHED_VALUE_NOISE_OCTAVES_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HVNO_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hvno assertion failed");
// next-cycle implication
`define HVNO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hvno assertion failed");
// implication after a fixed number of cycles
`define HVNO_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("hvno assertion failed");
`else
`define HVNO_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HVNO_ASSERT_NEXT(label, clk, rst, ante, cons)
`define HVNO_ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`endif

`endif

// ----- rtl/hvno_pkg.sv -----
// ----------------------------------------------------------------------------
// hvno_pkg
// Constants, types and helpers of the hashed value noise pipeline.
// ----------------------------------------------------------------------------
package hvno_pkg;

  localparam int MAX_OCTAVES = 4;
  localparam int OCT_CNT_W   = 3;
  localparam int EFF_W       = 4;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT   = 2'd2;

  // hash constants
  localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
  localparam logic [31:0] CHAN_MULT  = 32'h85ebca6b;
  localparam logic [31:0] LAT_OFFSET = 32'hc2b2ae35;
  localparam logic [31:0] MIX_MULT1  = 32'h7feb352d;
  localparam logic [31:0] MIX_MULT2  = 32'h846ca68b;

  // 3.0 in Q.16 for the smoothstep weight
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

  // register stages inside one octave lane, and the whole pipeline
  localparam int LANE_DEPTH = 8;
  localparam int PIPE_DEPTH = LANE_DEPTH + 2;

  typedef struct packed {
    logic [31:0] lattice;
    logic [15:0] frac;
    logic [31:0] chan;
  } hvno_lane_in_t;

  // octave count clamped to 1..MAX_OCTAVES
  function automatic logic [EFF_W-1:0] eff_octaves(input logic [OCT_CNT_W-1:0] n);
    logic [EFF_W-1:0] r;
    if (n == '0) begin
      r = EFF_W'(1);
    end else if (EFF_W'(n) > EFF_W'(MAX_OCTAVES)) begin
      r = EFF_W'(MAX_OCTAVES);
    end else begin
      r = EFF_W'(n);
    end
    return r;
  endfunction

endpackage

// ----- rtl/hashed_value_noise_octaves.sv -----
// ----------------------------------------------------------------------------
// hashed_value_noise_octaves
// Fractal 1-D value noise over up to four octaves, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive sample_time (signed Q16.16) and channel_id with start high;
//   the sample transfers on a rising edge where start is high and busy is low.
//   busy stays low, so a new sample may transfer in every cycle.
//   Output: noise_value (signed Q2.16) is shown for one cycle with
//   result_valid high and transfers once its sample has passed the register stages listed below.
//   Results leave in transfer order; the receiver cannot stall them.
//   Throughput: one sample per cycle. Latency is set by the register stages:
//   front multiplier, channel multiply, smoothstep multiply, four hash stages,
//   blend multiply, blend add and the octave sum.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   base_frequency, 1 noise_seed, 2 octave_count, others ignored. Write only
//   while no sample is in flight.
//   Reset (rst, synchronous): registers return to frequency 1.0, seed 0,
//   one octave, and the pipeline holds no results.
// ----------------------------------------------------------------------------
`include "hashed_value_noise_octaves_assert.svh"

module hashed_value_noise_octaves (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                sample_time,
  input  logic [31:0]                       channel_id,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hvno_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  output logic                              result_valid,
  output logic signed [17:0]                noise_value
);
  import hvno_pkg::*;

  logic [23:0]           base_frequency;
  logic [31:0]           noise_seed;
  logic [OCT_CNT_W-1:0]  octave_count;

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vpipe;

  logic signed [56:0]    p0;
  logic [31:0]           chan1;

  hvno_lane_in_t         lane_in [MAX_OCTAVES];
  logic signed [17:0]    blend   [MAX_OCTAVES];
  logic [EFF_W-1:0]      n_eff;
  logic signed [19:0]    sum_full;

  // fully pipelined, never holds off a sample
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign n_eff     = eff_octaves(octave_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= 24'd65536;
      noise_seed     <= '0;
      octave_count   <= OCT_CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_FREQUENCY: base_frequency <= cfg_data[23:0];
        REG_NOISE_SEED:     noise_seed     <= cfg_data;
        REG_OCTAVE_COUNT:   octave_count   <= cfg_data[OCT_CNT_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], accept};
    end
  end

  // scaled time with 32 fraction bits
  always_ff @(posedge clk) begin
    p0    <= 57'(sample_time) * 57'($signed({1'b0, base_frequency}));
    chan1 <= channel_id;
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_octave
    localparam logic [31:0] CHAN_STEP = 32'(32'(k) * GOLDEN);
    logic signed [63:0] pk;

    assign pk = 64'(p0) <<< k;
    assign lane_in[k].lattice = pk[63:32];
    assign lane_in[k].frac    = pk[31:16];
    assign lane_in[k].chan    = chan1 + CHAN_STEP;

    hvno_octave u_octave (
      .clk        (clk),
      .noise_seed (noise_seed),
      .lane_in    (lane_in[k]),
      .blend      (blend[k])
    );
  end

  // weighted octave sum, floor shift by octave index
  always_comb begin
    sum_full = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      if (EFF_W'(k) < n_eff) begin
        sum_full = sum_full + 20'(blend[k] >>> k);
      end
    end
  end

  always_ff @(posedge clk) begin
    noise_value <= sum_full[17:0];
  end

  assign result_valid = vpipe[PIPE_DEPTH-1];

  `HVNO_ASSERT_DELAY(a_result_follows, clk, rst, accept, PIPE_DEPTH, result_valid)
  `HVNO_ASSERT_IMPL(a_no_stray_result, clk, rst, result_valid, $past(accept, PIPE_DEPTH))
  `HVNO_ASSERT_IMPL(a_sum_fits, clk, rst, vpipe[PIPE_DEPTH-2], sum_full[19:17] == {3{sum_full[17]}})
  `HVNO_ASSERT_NEXT(a_octaves_clamped, clk, rst, cfg_valid && cfg_ready, n_eff != '0 && n_eff <= EFF_W'(MAX_OCTAVES))

endmodule

// ----- rtl/hvno_hash.sv -----
// ----------------------------------------------------------------------------
// hvno_hash
// Four-stage lattice hash: lattice mixing, two multiply rounds of the
// low-bias finalizer, then mapping to a signed Q.16 value in [-1,1).
// ----------------------------------------------------------------------------
module hvno_hash (
  input  logic               clk,
  input  logic [31:0]        mix_x,
  input  logic [31:0]        lattice,
  output logic signed [17:0] value
);
  import hvno_pkg::*;

  logic [31:0] xa;
  logic [31:0] y1;
  logic [31:0] m1;
  logic [31:0] z1;
  logic [31:0] m2;
  logic [31:0] h;

  assign xa = mix_x ^ (lattice + LAT_OFFSET + (mix_x << 6) + (mix_x >> 2));
  assign z1 = m1 ^ (m1 >> 15);
  assign h  = m2 ^ (m2 >> 16);

  always_ff @(posedge clk) begin
    y1    <= xa ^ (xa >> 16);
    m1    <= 32'(y1 * MIX_MULT1);
    m2    <= 32'(z1 * MIX_MULT2);
    value <= 18'($signed({1'b0, h[31:15]}) - 18'sd65536);
  end

endmodule

// ----- rtl/hvno_octave.sv -----
// ----------------------------------------------------------------------------
// hvno_octave
// One octave lane: channel mixing, hashes of both lattice neighbors,
// smoothstep weight and the interpolated blend.
// ----------------------------------------------------------------------------
module hvno_octave (
  input  logic                    clk,
  input  logic [31:0]             noise_seed,
  input  hvno_pkg::hvno_lane_in_t lane_in,
  output logic signed [17:0]      blend
);
  import hvno_pkg::*;

  // stage 2
  logic [31:0] chan_mul;
  logic [31:0] frac_sq;
  logic [15:0] frac2;
  logic [31:0] lat2;
  // stage 3
  logic [31:0] mix_x;
  logic [31:0] lat_a;
  logic [31:0] lat_b;
  logic [17:0] factor;
  logic [49:0] smooth_prod;
  logic [15:0] smooth_dly [5];
  // stages 7 to 9
  logic signed [17:0] val_a;
  logic signed [17:0] val_b;
  logic signed [17:0] diff;
  logic signed [34:0] weighted;
  logic signed [17:0] base_a;

  assign factor      = SMOOTH_THREE - {1'b0, frac2, 1'b0};
  assign smooth_prod = 50'(frac_sq) * 50'(factor);
  assign diff        = val_b - val_a;

  always_ff @(posedge clk) begin
    chan_mul <= 32'(lane_in.chan * CHAN_MULT);
    frac_sq  <= 32'(lane_in.frac) * 32'(lane_in.frac);
    frac2    <= lane_in.frac;
    lat2     <= lane_in.lattice;

    mix_x         <= noise_seed ^ (GOLDEN + chan_mul);
    lat_a         <= lat2;
    lat_b         <= lat2 + 32'd1;
    smooth_dly[0] <= smooth_prod[47:32];

    // weight waits for the hash units
    smooth_dly[1] <= smooth_dly[0];
    smooth_dly[2] <= smooth_dly[1];
    smooth_dly[3] <= smooth_dly[2];
    smooth_dly[4] <= smooth_dly[3];

    weighted <= 35'(diff) * 35'($signed({1'b0, smooth_dly[4]}));
    base_a   <= val_a;

    blend <= 18'(19'(base_a) + 19'(weighted >>> 16));
  end

  hvno_hash u_hash_a (
    .clk     (clk),
    .mix_x   (mix_x),
    .lattice (lat_a),
    .value   (val_a)
  );

  hvno_hash u_hash_b (
    .clk     (clk),
    .mix_x   (mix_x),
    .lattice (lat_b),
    .value   (val_b)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fractal value noise block: the octave sum is
// recomputed in fixed point for every transferred sample and compared with
// the strobed result, over several register settings and random gaps.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [31:0] HASH_GOLDEN  = 32'h9e3779b9;
  localparam logic [31:0] HASH_CHAN    = 32'h85ebca6b;
  localparam logic [31:0] HASH_LATTICE = 32'hc2b2ae35;
  localparam logic [31:0] MIX_A        = 32'h7feb352d;
  localparam logic [31:0] MIX_B        = 32'h846ca68b;
  localparam int          OCT_LIMIT    = 4;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam int          PHASE_ITEMS  = 179;

  typedef struct {
    logic [31:0] t;
    logic [31:0] chan;
  } sample_t;

  typedef struct {
    logic [31:0] t;
    logic [31:0] chan;
    logic [17:0] noise;
  } noise_exp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [31:0]           sample_time = '0;
  logic [31:0]                  channel_id = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [hvno_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                  cfg_data = '0;
  logic                         result_valid;
  logic signed [17:0]           noise_value;

  // register copies used for prediction
  logic [23:0] freq_q16 = 24'd65536;
  logic [31:0] seed_word = '0;
  logic [2:0]  octaves_raw = 3'd1;

  sample_t    sample_q[$];
  noise_exp_t noise_q[$];
  int         fail_count = 0;
  int         gap_left = 0;
  bit         burst = 1'b0;

  hashed_value_noise_octaves i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_time  (sample_time),
    .channel_id   (channel_id),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .noise_value  (noise_value)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] lowbias(logic [31:0] x);
    x ^= x >> 16;
    x *= MIX_A;
    x ^= x >> 15;
    x *= MIX_B;
    x ^= x >> 16;
    return x;
  endfunction

  // lattice hash mapped to [-1,1) in Q.16
  function automatic longint lattice_level(logic [31:0] chan, logic [31:0] lat);
    logic [31:0] x;
    logic [31:0] h;
    x = seed_word;
    x ^= HASH_GOLDEN + chan * HASH_CHAN;
    x ^= lat + HASH_LATTICE + (x << 6) + (x >> 2);
    h = lowbias(x);
    return longint'(h[31:15]) - 64'sd65536;
  endfunction

  function automatic logic [17:0] noise_at(logic [31:0] t, logic [31:0] chan);
    logic [63:0] mag;
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] s;
    logic [31:0] lat;
    logic [31:0] ochan;
    logic [31:0] kk;
    longint      a;
    longint      b;
    longint      v;
    longint      total;
    int          n;
    mag = t[31] ? {32'd0, (32'd0 - t)} : {32'd0, t};
    n = int'(octaves_raw);
    if (n < 1) n = 1;
    if (n > OCT_LIMIT) n = OCT_LIMIT;
    total = 0;
    for (int k = 0; k < n; k++) begin
      p = (mag * {40'd0, freq_q16}) << k;
      if (t[31]) p = 64'd0 - p;
      lat = p[63:32];
      f = {48'd0, p[31:16]};
      s = (f * f * (64'd196608 - 64'd2 * f)) >> 32;
      kk = 32'(k);
      ochan = chan + kk * HASH_GOLDEN;
      a = lattice_level(ochan, lat);
      b = lattice_level(ochan, lat + 32'd1);
      v = a + (((b - a) * longint'(s)) >>> 16);
      total += v >>> k;
    end
    return total[17:0];
  endfunction

  // sample driver
  always @(posedge clk) begin
    sample_t    item;
    noise_exp_t e;
    logic       start_n;
    start_n = start;
    if (rst) begin
      start_n = 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        e.t = sample_time;
        e.chan = channel_id;
        e.noise = noise_at(sample_time, channel_id);
        noise_q = {noise_q, e};
        if ($urandom_range(0, 31) == 0) burst = ~burst;
        gap_left = burst ? 0 : $urandom_range(0, 11);
        start_n = 1'b0;
      end
      if (!start_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() > 0) begin
          item = sample_q.pop_front();
          sample_time <= item.t;
          channel_id <= item.chan;
          start_n = 1'b1;
        end
      end
    end
    start <= start_n;
  end

  // result monitor
  always @(posedge clk) begin
    noise_exp_t e;
    if (!rst && result_valid) begin
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, noise_value);
        fail_count++;
      end else begin
        e = noise_q.pop_front();
        if (noise_value !== e.noise) begin
          $display("%0t: noise_value mismatch (t=%h chan=%h) expected %h actual %h",
                   $time, e.t, e.chan, e.noise, noise_value);
          fail_count++;
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hvno_pkg::REG_BASE_FREQUENCY: freq_q16 = data[23:0];
      hvno_pkg::REG_NOISE_SEED:     seed_word = data;
      hvno_pkg::REG_OCTAVE_COUNT:   octaves_raw = data[2:0];
      default: ;
    endcase
  endtask

  task automatic add_sample(logic [31:0] t, logic [31:0] chan);
    sample_t item;
    item.t = t;
    item.chan = chan;
    sample_q = {sample_q, item};
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sample_q.size() > 0 || start || noise_q.size() > 0);
  endtask

  function automatic logic [31:0] random_time();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = $urandom;
      4, 5:       t = $urandom_range(0, 32'h0003ffff);
      6:          t = 32'd0 - $urandom_range(0, 32'h0003ffff);
      // right on or just below a lattice point
      7:          t = {16'($urandom), 16'h0000} |
                      ($urandom_range(0, 1) ? 32'h0000ffff : 32'h0);
      8:          t = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default:    t = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
    endcase
    return t;
  endfunction

  task automatic run_phase(logic [23:0] freq, logic [31:0] seed, logic [2:0] oct);
    logic [31:0] chan;
    cfg_write(hvno_pkg::REG_BASE_FREQUENCY, {8'($urandom), freq});
    cfg_write(hvno_pkg::REG_NOISE_SEED, seed);
    cfg_write(hvno_pkg::REG_OCTAVE_COUNT, {29'($urandom), oct});
    cfg_write(REG_UNUSED, $urandom);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      @(negedge clk);
      chan = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom;
      add_sample(random_time(), chan);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed samples at the reset settings
    @(negedge clk);
    add_sample(32'h00000000, 32'h00000000);
    add_sample(32'h00000001, 32'h00000000);
    add_sample(32'hffffffff, 32'h00000000);
    add_sample(32'h7fffffff, 32'hffffffff);
    add_sample(32'h80000000, 32'hffffffff);
    add_sample(32'h80000001, 32'h00000001);
    add_sample(32'h00010000, 32'h00000000);
    add_sample(32'hffff0000, 32'h00000000);
    add_sample(32'h0000ffff, 32'h00000005);
    add_sample(32'hffff0001, 32'h00000005);
    add_sample(32'h00008000, 32'h12345678);
    add_sample(32'hffff8000, 32'h12345678);
    add_sample(32'h00004000, 32'h80000000);
    add_sample(32'h0000c000, 32'h7fffffff);
    add_sample(32'h00020000, 32'h00000003);
    add_sample(32'h5a5aa5a5, 32'ha5a55a5a);
    add_sample(32'ha5a55a5a, 32'h5a5aa5a5);
    add_sample(32'h00000100, 32'hdeadbeef);
    add_sample(32'hffffff00, 32'hdeadbeef);
    add_sample(32'h12340000, 32'h00000002);
    wait_drained();

    // extremes first, then random settings
    run_phase(24'd0,        32'h7fffffff, 3'd4);
    run_phase(24'hffffff,   32'h80000000, 3'd7);
    run_phase(24'($urandom), $urandom,    3'd0);
    run_phase(24'd1,        32'hffffffff, 3'd2);
    run_phase(24'd65536,    $urandom,     3'd3);
    run_phase(24'($urandom), $urandom,    3'd5);
    run_phase(24'($urandom_range(0, 32'h3ffff)), $urandom, 3'd4);
    run_phase(24'($urandom), $urandom,    3'($urandom_range(0, 7)));

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hvno_pkg.sv
rtl/hvno_hash.sv
rtl/hvno_octave.sv
rtl/hashed_value_noise_octaves.sv
tb/sv/tb.sv
